FILE: hdl/int32_divide_modulo_unit_macros.svh
// ----------------------------------------------------------------------------
// int32_divide_modulo_unit_macros
// assertion helpers for the divide unit; they assume clk and arst_n in scope
// ----------------------------------------------------------------------------
`ifndef INT32_DIVIDE_MODULO_UNIT_MACROS_SVH
`define INT32_DIVIDE_MODULO_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IDM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define IDM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define IDM_ASSERT_NOW(label, ante, cons)

`define IDM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hdl/idm_pkg.sv
// ----------------------------------------------------------------------------
// idm_pkg
// shared constants, operation codes and stage control type of the divide unit
// ----------------------------------------------------------------------------
package idm_pkg;

	// default operand width
	localparam int DATA_WIDTH_DEF = 32;

	// operation codes
	typedef enum logic [1:0] {
		OP_SDIV = 2'd0,
		OP_SREM = 2'd1,
		OP_UDIV = 2'd2,
		OP_UREM = 2'd3
	} op_t;

	// control that rides along with each word through the pipeline
	typedef struct packed {
		logic quot;  // deliver quotient, else remainder
		logic neg;   // negate the delivered value
	} ctrl_t;

endpackage

FILE: hdl/idm_prep.sv
// ----------------------------------------------------------------------------
// idm_prep
// operand conditioning: decodes the operation, takes magnitudes for signed
// operations and works out the final sign, then registers the word
// ----------------------------------------------------------------------------
module idm_prep #(
	parameter int DATA_WIDTH = idm_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  logic [1:0]            in_op,
	input  logic [DATA_WIDTH-1:0] in_num,
	input  logic [DATA_WIDTH-1:0] in_den,
	output logic                  out_valid,
	output idm_pkg::ctrl_t        out_ctrl,
	output logic [DATA_WIDTH-1:0] out_num,
	output logic [DATA_WIDTH-1:0] out_den
);

	logic                  signed_op;
	logic                  num_neg;
	logic                  den_neg;
	idm_pkg::ctrl_t        ctrl;
	logic [DATA_WIDTH-1:0] mag_num;
	logic [DATA_WIDTH-1:0] mag_den;
	logic                  valid_s1;
	idm_pkg::ctrl_t        ctrl_s1;
	logic [DATA_WIDTH-1:0] num_s1;
	logic [DATA_WIDTH-1:0] den_s1;

	// decode and sign handling
	always_comb begin
		signed_op = (in_op == idm_pkg::OP_SDIV) || (in_op == idm_pkg::OP_SREM);
		num_neg   = signed_op & in_num[DATA_WIDTH-1];
		den_neg   = signed_op & in_den[DATA_WIDTH-1];
		ctrl.quot = (in_op == idm_pkg::OP_SDIV) || (in_op == idm_pkg::OP_UDIV);
		ctrl.neg  = ctrl.quot ? (num_neg ^ den_neg) : num_neg;
		mag_num   = num_neg ? (~in_num + 1'b1) : in_num;
		mag_den   = den_neg ? (~in_den + 1'b1) : in_den;
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s1 <= ctrl;
			num_s1  <= mag_num;
			den_s1  <= mag_den;
		end
	end

	assign out_valid = valid_s1;
	assign out_ctrl  = ctrl_s1;
	assign out_num   = num_s1;
	assign out_den   = den_s1;

endmodule

FILE: hdl/idm_step.sv
// ----------------------------------------------------------------------------
// idm_step
// one restoring division step: shifts in the next dividend bit, trial
// subtracts the divisor and shifts the quotient bit into the dividend register
// ----------------------------------------------------------------------------
module idm_step #(
	parameter int DATA_WIDTH = idm_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  idm_pkg::ctrl_t        in_ctrl,
	input  logic [DATA_WIDTH-1:0] in_rem,
	input  logic [DATA_WIDTH-1:0] in_nq,
	input  logic [DATA_WIDTH-1:0] in_den,
	output logic                  out_valid,
	output idm_pkg::ctrl_t        out_ctrl,
	output logic [DATA_WIDTH-1:0] out_rem,
	output logic [DATA_WIDTH-1:0] out_nq,
	output logic [DATA_WIDTH-1:0] out_den
);

	logic [DATA_WIDTH:0]   diff;
	logic                  borrow;
	logic [DATA_WIDTH-1:0] rem_next;
	logic [DATA_WIDTH-1:0] nq_next;
	logic                  valid_s1;
	idm_pkg::ctrl_t        ctrl_s1;
	logic [DATA_WIDTH-1:0] rem_s1;
	logic [DATA_WIDTH-1:0] nq_s1;
	logic [DATA_WIDTH-1:0] den_s1;

	// trial subtract; the partial remainder stays below the divisor, so the
	// restored value always fits the word
	always_comb begin
		diff     = {in_rem, in_nq[DATA_WIDTH-1]} - {1'b0, in_den};
		borrow   = diff[DATA_WIDTH];
		rem_next = borrow ? {in_rem[DATA_WIDTH-2:0], in_nq[DATA_WIDTH-1]}
			: diff[DATA_WIDTH-1:0];
		nq_next  = {in_nq[DATA_WIDTH-2:0], ~borrow};
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s1 <= in_ctrl;
			rem_s1  <= rem_next;
			nq_s1   <= nq_next;
			den_s1  <= in_den;
		end
	end

	assign out_valid = valid_s1;
	assign out_ctrl  = ctrl_s1;
	assign out_rem   = rem_s1;
	assign out_nq    = nq_s1;
	assign out_den   = den_s1;

endmodule

FILE: hdl/idm_post.sv
// ----------------------------------------------------------------------------
// idm_post
// result selection and sign fix-up, into the output register
// ----------------------------------------------------------------------------
module idm_post #(
	parameter int DATA_WIDTH = idm_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  idm_pkg::ctrl_t        in_ctrl,
	input  logic [DATA_WIDTH-1:0] in_rem,
	input  logic [DATA_WIDTH-1:0] in_quo,
	output logic                  out_valid,
	output logic [DATA_WIDTH-1:0] out_result
);

	logic [DATA_WIDTH-1:0] picked;
	logic [DATA_WIDTH-1:0] fixed;
	logic                  valid_s1;
	logic [DATA_WIDTH-1:0] result_s1;

	// pick quotient or remainder, negate when the signs call for it
	always_comb begin
		picked = in_ctrl.quot ? in_quo : in_rem;
		fixed  = in_ctrl.neg ? (~picked + 1'b1) : picked;
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	// output data
	always_ff @(posedge clk) begin
		if (adv) begin
			result_s1 <= fixed;
		end
	end

	assign out_valid  = valid_s1;
	assign out_result = result_s1;

endmodule

FILE: hdl/int32_divide_modulo_unit.sv
// ----------------------------------------------------------------------------
// int32_divide_modulo_unit
// Pipelined integer divide and remainder, signed and unsigned. One word is
// taken every cycle while cmd_stall is low. A first register stage takes
// operand magnitudes, then comes one pipeline stage per quotient bit, each
// holding a single restoring subtractor, and a last stage picks and signs
// the result. Signed quotients truncate toward zero and signed remainders
// take the dividend's sign. Divide by zero gives an all-ones unsigned
// quotient (1 for a signed quotient with a negative dividend) and a
// remainder equal to the dividend; the most negative value divided by minus
// one wraps to itself. The whole pipeline holds while a result waits on
// res_stall; a one-word skid register at the input still takes a word in
// that cycle, and cmd_stall is driven straight from that register.
// ----------------------------------------------------------------------------
`include "int32_divide_modulo_unit_macros.svh"

module int32_divide_modulo_unit #(
	parameter int DATA_WIDTH = idm_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  logic [1:0]            op,
	input  logic [DATA_WIDTH-1:0] numerator,
	input  logic [DATA_WIDTH-1:0] denominator,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [DATA_WIDTH-1:0] result
);

	logic                  adv;
	logic                  skid_q;
	logic [1:0]            op_q;
	logic [DATA_WIDTH-1:0] num_q;
	logic [DATA_WIDTH-1:0] den_q;
	logic                  sel_valid;
	logic [1:0]            sel_op;
	logic [DATA_WIDTH-1:0] sel_num;
	logic [DATA_WIDTH-1:0] sel_den;

	logic                  valid_w [0:DATA_WIDTH];
	idm_pkg::ctrl_t        ctrl_w  [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] rem_w   [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] nq_w    [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] den_w   [0:DATA_WIDTH];

	// pipeline moves unless a finished word is held at the output
	assign adv       = !(res_valid && res_stall);
	assign cmd_stall = skid_q;

	// input skid register: holds one word taken while the pipeline is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (adv) begin
			skid_q <= 1'b0;
		end else if (cmd_valid && !skid_q) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && cmd_valid && !skid_q) begin
			op_q  <= op;
			num_q <= numerator;
			den_q <= denominator;
		end
	end

	// pipeline feed: skid word first, else the incoming word
	always_comb begin
		sel_valid = skid_q | cmd_valid;
		sel_op    = skid_q ? op_q : op;
		sel_num   = skid_q ? num_q : numerator;
		sel_den   = skid_q ? den_q : denominator;
	end

	// operand conditioning
	idm_prep #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (sel_valid),
		.in_op     (sel_op),
		.in_num    (sel_num),
		.in_den    (sel_den),
		.out_valid (valid_w[0]),
		.out_ctrl  (ctrl_w[0]),
		.out_num   (nq_w[0]),
		.out_den   (den_w[0])
	);

	assign rem_w[0] = '0;

	// one restoring step per stage
	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
		idm_step #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (valid_w[i]),
			.in_ctrl   (ctrl_w[i]),
			.in_rem    (rem_w[i]),
			.in_nq     (nq_w[i]),
			.in_den    (den_w[i]),
			.out_valid (valid_w[i+1]),
			.out_ctrl  (ctrl_w[i+1]),
			.out_rem   (rem_w[i+1]),
			.out_nq    (nq_w[i+1]),
			.out_den   (den_w[i+1])
		);
	end

	// result select, sign fix and output register
	idm_post #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (valid_w[DATA_WIDTH]),
		.in_ctrl    (ctrl_w[DATA_WIDTH]),
		.in_rem     (rem_w[DATA_WIDTH]),
		.in_quo     (nq_w[DATA_WIDTH]),
		.out_valid  (res_valid),
		.out_result (result)
	);

	// skid fills only while the pipeline is held
	`IDM_ASSERT_NEXT(a_skid_fill_on_hold, !skid_q && adv, !skid_q)

	// a held skid word drains on the next advance
	`IDM_ASSERT_NEXT(a_skid_drains, skid_q && adv, !skid_q)

	// first stage keeps its valid while the pipeline is held
	`IDM_ASSERT_NEXT(a_hold_keeps_stage, !adv, $stable(valid_w[0]))

endmodule
